@@ sv/arxsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arxsc_pkg
// Shared types, constants and the round schedule of the ARX keystream block.
// ----------------------------------------------------------------------------
package arxsc_pkg;

    localparam int ROUNDS     = 16;
    localparam int RoundW     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int WordW      = 32;
    localparam int StateDepth = 16;
    localparam int AddrW      = $clog2(StateDepth);
    localparam int ChunkW     = 64;
    localparam int CfgIdxW    = 3;

    localparam logic [RoundW-1:0] LastRound = RoundW'(ROUNDS - 1);
    localparam logic [AddrW-1:0]  LastStep  = AddrW'(StateDepth - 1);
    localparam logic [AddrW-1:0]  LastLoad  = AddrW'(StateDepth - 1);
    localparam logic [AddrW-1:0]  KsLastCnt = AddrW'(4);

    localparam logic [WordW-1:0] FillConst0 = 32'hed21b71b;
    localparam logic [WordW-1:0] FillConst1 = 32'he3b4d73a;
    localparam logic [WordW-1:0] FillConst2 = 32'h85f2eb43;
    localparam logic [WordW-1:0] FillConst3 = 32'h9b5240c2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgKey0     = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgKey1     = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgKey2     = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgKey3     = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgNonceHi  = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgNonceLo  = 3'd5;

    typedef struct packed {
        logic [ChunkW-1:0] key0;
        logic [ChunkW-1:0] key1;
        logic [ChunkW-1:0] key2;
        logic [ChunkW-1:0] key3;
        logic [ChunkW-1:0] nonce_hi;
        logic [ChunkW-1:0] nonce_lo;
    } cfg_regs_t;

    // one chained update: dst = dst op_o rotl(src_b op_i src_c, rot)
    typedef struct packed {
        logic [AddrW-1:0] dst;
        logic [AddrW-1:0] src_b;
        logic [AddrW-1:0] src_c;
        logic             inner_add;
        logic             outer_add;
        logic [4:0]       rot;
    } step_t;

    typedef struct packed {
        logic start;
        logic load;
    } eng_cmd_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_LOAD,
        ENG_FETCH,
        ENG_APPLY,
        ENG_KS
    } eng_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_GEN,
        TOP_OUT
    } top_state_t;

    function automatic step_t step_ctl(input logic [AddrW-1:0] idx);
        step_t s;
        unique case (idx)
            4'd0:  s = '{4'd8,  4'd10, 4'd3,  1'b1, 1'b0, 5'd7};
            4'd1:  s = '{4'd15, 4'd14, 4'd6,  1'b0, 1'b1, 5'd21};
            4'd2:  s = '{4'd9,  4'd11, 4'd0,  1'b0, 1'b1, 5'd17};
            4'd3:  s = '{4'd5,  4'd7,  4'd12, 1'b0, 1'b1, 5'd9};
            4'd4:  s = '{4'd2,  4'd2,  4'd9,  1'b1, 1'b0, 5'd13};
            4'd5:  s = '{4'd11, 4'd9,  4'd2,  1'b0, 1'b1, 5'd19};
            4'd6:  s = '{4'd4,  4'd4,  4'd15, 1'b1, 1'b0, 5'd6};
            4'd7:  s = '{4'd6,  4'd6,  4'd13, 1'b1, 1'b0, 5'd14};
            4'd8:  s = '{4'd13, 4'd12, 4'd4,  1'b0, 1'b1, 5'd9};
            4'd9:  s = '{4'd0,  4'd0,  4'd11, 1'b1, 1'b0, 5'd7};
            4'd10: s = '{4'd7,  4'd5,  4'd14, 1'b0, 1'b1, 5'd21};
            4'd11: s = '{4'd14, 4'd13, 4'd5,  1'b1, 1'b1, 5'd14};
            4'd12: s = '{4'd10, 4'd8,  4'd1,  1'b1, 1'b1, 5'd13};
            4'd13: s = '{4'd3,  4'd1,  4'd10, 1'b0, 1'b1, 5'd19};
            4'd14: s = '{4'd12, 4'd15, 4'd7,  1'b1, 1'b0, 5'd6};
            4'd15: s = '{4'd1,  4'd3,  4'd8,  1'b0, 1'b1, 5'd17};
        endcase
        return s;
    endfunction

    // logical word to RAM row; base tracks the one-word rotation per block
    function automatic logic [AddrW-1:0] phys_addr(input logic [AddrW-1:0] lw,
                                                   input logic [AddrW-1:0] base);
        return lw + base;
    endfunction

endpackage

@@ sv/arxsc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arxsc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module arxsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read-before-write on a shared address
    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ sv/arxsc_arx.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arxsc_arx
// Shared add-rotate-xor unit: one chained state update per use.
// ----------------------------------------------------------------------------
module arxsc_arx (
    input  arxsc_pkg::step_t              ctl,
    input  logic [arxsc_pkg::WordW-1:0]   dst_word,
    input  logic [arxsc_pkg::WordW-1:0]   b_word,
    input  logic [arxsc_pkg::WordW-1:0]   c_word,
    output logic [arxsc_pkg::WordW-1:0]   result
);

    logic [arxsc_pkg::WordW-1:0]   inner;
    logic [2*arxsc_pkg::WordW-1:0] dbl;
    logic [arxsc_pkg::WordW-1:0]   rotated;

    always_comb
    begin
        inner   = ctl.inner_add ? (b_word + c_word) : (b_word ^ c_word);
        dbl     = {inner, inner} << ctl.rot;
        rotated = dbl[2*arxsc_pkg::WordW-1:arxsc_pkg::WordW];
        result  = ctl.outer_add ? (dst_word + rotated) : (dst_word ^ rotated);
    end

endmodule

@@ sv/arxsc_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arxsc_engine
// State RAM, sequencer and keystream registers around the shared ARX unit.
// ----------------------------------------------------------------------------
module arxsc_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  arxsc_pkg::cfg_regs_t           cfg,
    input  arxsc_pkg::eng_cmd_t            cmd,
    input  logic [1:0]                     ks_sel,
    output logic                           done,
    output logic [arxsc_pkg::ChunkW-1:0]   ks
);

    localparam int AW = arxsc_pkg::AddrW;
    localparam int W  = arxsc_pkg::WordW;

    arxsc_pkg::eng_state_t           state_reg, state_next;
    logic [AW-1:0]                   cnt_reg, cnt_next;
    logic [AW-1:0]                   step_reg, step_next;
    logic [arxsc_pkg::RoundW-1:0]    round_reg, round_next;
    logic [AW-1:0]                   base_reg, base_next;

    arxsc_pkg::step_t                ctl;
    logic                            we;
    logic [AW-1:0]                   waddr;
    logic [W-1:0]                    wdata;
    logic [W-1:0]                    load_word;
    logic [W-1:0]                    arx_out;
    logic [AW-1:0]                   ra0, ra1, rc0, rc1;
    logic [W-1:0]                    rda0, rda1, rdc0, rdc1;
    logic [1:0]                      pair;
    logic [AW-1:0]                   cnt_dec;
    logic                            ks_we;
    logic [1:0]                      ks_widx;
    logic [arxsc_pkg::ChunkW-1:0]    ks_reg [4];

    assign ctl     = arxsc_pkg::step_ctl(step_reg);
    assign pair    = cnt_reg[1:0];
    assign cnt_dec = cnt_reg - AW'(1);
    assign ks_widx = cnt_dec[1:0];
    assign ks      = ks_reg[ks_sel];

    // two copies of the state so that one update reads three words at once
    arxsc_ram #(.WIDTH(W), .DEPTH(arxsc_pkg::StateDepth)) u_ram_ab (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (ra0),
        .raddr1 (ra1),
        .rdata0 (rda0),
        .rdata1 (rda1)
    );

    arxsc_ram #(.WIDTH(W), .DEPTH(arxsc_pkg::StateDepth)) u_ram_c (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (rc0),
        .raddr1 (rc1),
        .rdata0 (rdc0),
        .rdata1 (rdc1)
    );

    arxsc_arx u_arx (
        .ctl      (ctl),
        .dst_word (rda0),
        .b_word   (rda1),
        .c_word   (rdc0),
        .result   (arx_out)
    );

    always_comb
    begin
        unique case (cnt_reg)
            4'd0:  load_word = cfg.key0[63:32];
            4'd1:  load_word = cfg.nonce_hi[63:32];
            4'd2:  load_word = cfg.key0[31:0];
            4'd3:  load_word = cfg.nonce_hi[31:0];
            4'd4:  load_word = cfg.key1[63:32];
            4'd5:  load_word = cfg.nonce_lo[63:32];
            4'd6:  load_word = cfg.key1[31:0];
            4'd7:  load_word = cfg.nonce_lo[31:0];
            4'd8:  load_word = cfg.key2[63:32];
            4'd9:  load_word = arxsc_pkg::FillConst0;
            4'd10: load_word = cfg.key2[31:0];
            4'd11: load_word = arxsc_pkg::FillConst1;
            4'd12: load_word = cfg.key3[63:32];
            4'd13: load_word = arxsc_pkg::FillConst2;
            4'd14: load_word = cfg.key3[31:0];
            4'd15: load_word = arxsc_pkg::FillConst3;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        round_next = round_reg;
        base_next  = base_reg;
        done       = 1'b0;
        we         = 1'b0;
        waddr      = cnt_reg;
        wdata      = load_word;
        ra0        = '0;
        ra1        = '0;
        rc0        = '0;
        rc1        = '0;
        ks_we      = 1'b0;

        unique case (state_reg)
            arxsc_pkg::ENG_IDLE:
            begin
                if (cmd.start)
                begin
                    step_next  = '0;
                    round_next = '0;
                    cnt_next   = '0;
                    if (cmd.load)
                    begin
                        base_next  = '0;
                        state_next = arxsc_pkg::ENG_LOAD;
                    end
                    else
                    begin
                        state_next = arxsc_pkg::ENG_FETCH;
                    end
                end
            end
            arxsc_pkg::ENG_LOAD:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == arxsc_pkg::LastLoad)
                begin
                    state_next = arxsc_pkg::ENG_FETCH;
                end
            end
            arxsc_pkg::ENG_FETCH:
            begin
                ra0        = arxsc_pkg::phys_addr(ctl.dst, base_reg);
                ra1        = arxsc_pkg::phys_addr(ctl.src_b, base_reg);
                rc0        = arxsc_pkg::phys_addr(ctl.src_c, base_reg);
                rc1        = rc0;
                state_next = arxsc_pkg::ENG_APPLY;
            end
            arxsc_pkg::ENG_APPLY:
            begin
                we         = 1'b1;
                waddr      = arxsc_pkg::phys_addr(ctl.dst, base_reg);
                wdata      = arx_out;
                step_next  = step_reg + AW'(1);
                state_next = arxsc_pkg::ENG_FETCH;
                if (step_reg == arxsc_pkg::LastStep)
                begin
                    if (round_reg == arxsc_pkg::LastRound)
                    begin
                        round_next = '0;
                        cnt_next   = '0;
                        state_next = arxsc_pkg::ENG_KS;
                    end
                    else
                    begin
                        round_next = round_reg + arxsc_pkg::RoundW'(1);
                    end
                end
            end
            arxsc_pkg::ENG_KS:
            begin
                // read pair p, fold words 2p, 2p+1 with 2p+8, 2p+9 in the next cycle
                ra0      = arxsc_pkg::phys_addr({1'b0, pair, 1'b0}, base_reg);
                ra1      = arxsc_pkg::phys_addr({1'b1, pair, 1'b0}, base_reg);
                rc0      = arxsc_pkg::phys_addr({1'b0, pair, 1'b1}, base_reg);
                rc1      = arxsc_pkg::phys_addr({1'b1, pair, 1'b1}, base_reg);
                ks_we    = (cnt_reg != '0);
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == arxsc_pkg::KsLastCnt)
                begin
                    done       = 1'b1;
                    base_next  = base_reg + AW'(1);
                    state_next = arxsc_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = arxsc_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arxsc_pkg::ENG_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            round_reg <= '0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            round_reg <= round_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ks_we)
        begin
            ks_reg[ks_widx] <= {rda0 ^ rda1, rdc0 ^ rdc1};
        end
    end

endmodule

@@ sv/arx_stream_cipher_keystream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arx_stream_cipher_keystream
// 512-bit ARX keystream generator that scrambles 64-bit words.
// ----------------------------------------------------------------------------
// Each accepted 64-bit word is xored with the next 64 bits of keystream. Every
// word then passes through the output state, which forms the result and goes
// back to idle so that s_tready returns; it waits there while the output
// register is held by m_tready. The first word after a restart, and every
// fourth word after it, also waits for a new 256-bit keystream block:
// 16 * ROUNDS updates on the single shared ARX unit, each a fetch from the
// state RAM then a write back, then a fold of the state into the keystream
// registers, all preceded by a load of key and nonce into the state RAM when
// restart is set. s_tready is low while a word is being worked on. Key and
// nonce registers must be written only while the block is idle, which the
// block itself does not enforce; a restart must come before the first word.
// ----------------------------------------------------------------------------
module arx_stream_cipher_keystream (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arxsc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [arxsc_pkg::ChunkW-1:0]      cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [arxsc_pkg::ChunkW-1:0]      s_tdata,   // [63:0] data_in
    input  logic                              s_tuser,   // [0] restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [arxsc_pkg::ChunkW-1:0]      m_tdata    // [63:0] data_out
);

    arxsc_pkg::top_state_t           state_reg, state_next;
    logic [1:0]                      chunk_reg, chunk_next;
    logic [arxsc_pkg::ChunkW-1:0]    data_reg, data_next;
    logic                            out_valid_reg, out_valid_next;
    logic [arxsc_pkg::ChunkW-1:0]    out_data_reg, out_data_next;
    arxsc_pkg::cfg_regs_t            cfg_reg;
    arxsc_pkg::eng_cmd_t             eng_cmd;
    logic                            eng_done;
    logic [arxsc_pkg::ChunkW-1:0]    ks;
    logic                            accept;
    logic                            out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == arxsc_pkg::TOP_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                arxsc_pkg::CfgKey0:    cfg_reg.key0     <= cfg_data;
                arxsc_pkg::CfgKey1:    cfg_reg.key1     <= cfg_data;
                arxsc_pkg::CfgKey2:    cfg_reg.key2     <= cfg_data;
                arxsc_pkg::CfgKey3:    cfg_reg.key3     <= cfg_data;
                arxsc_pkg::CfgNonceHi: cfg_reg.nonce_hi <= cfg_data;
                arxsc_pkg::CfgNonceLo: cfg_reg.nonce_lo <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    arxsc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .cmd    (eng_cmd),
        .ks_sel (chunk_reg),
        .done   (eng_done),
        .ks     (ks)
    );

    always_comb
    begin
        state_next     = state_reg;
        chunk_next     = chunk_reg;
        data_next      = data_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        eng_cmd        = '{start: 1'b0, load: s_tuser};

        unique case (state_reg)
            arxsc_pkg::TOP_IDLE:
            begin
                if (accept)
                begin
                    data_next = s_tdata;
                    if (s_tuser)
                    begin
                        chunk_next = '0;
                    end
                    // fresh block before the first word of every four
                    if (s_tuser || chunk_reg == 2'd0)
                    begin
                        eng_cmd.start = 1'b1;
                        state_next    = arxsc_pkg::TOP_GEN;
                    end
                    else
                    begin
                        state_next = arxsc_pkg::TOP_OUT;
                    end
                end
            end
            arxsc_pkg::TOP_GEN:
            begin
                if (eng_done)
                begin
                    state_next = arxsc_pkg::TOP_OUT;
                end
            end
            arxsc_pkg::TOP_OUT:
            begin
                if (out_free)
                begin
                    out_data_next  = data_reg ^ ks;
                    out_valid_next = 1'b1;
                    chunk_next     = chunk_reg + 2'd1;
                    state_next     = arxsc_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = arxsc_pkg::TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arxsc_pkg::TOP_IDLE;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

    a_mid_block_skips_engine: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser && chunk_reg != 2'd0) |=> (state_reg == arxsc_pkg::TOP_OUT))
        else $error("mid-block word did not go straight to output");

    a_restart_starts_block: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> (state_reg == arxsc_pkg::TOP_GEN && chunk_reg == 2'd0))
        else $error("restart did not start a new block at word zero");

    a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        eng_done |-> (state_reg == arxsc_pkg::TOP_GEN))
        else $error("keystream block finished with no word waiting");

    a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arxsc_pkg::TOP_OUT && out_free) |=>
            (m_tvalid && chunk_reg == $past(chunk_reg) + 2'd1))
        else $error("result not registered or word counter not advanced");

endmodule
